[hw/rtl/mcpl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mcpl_pkg;

   localparam int MOTOR_COUNT = 4;
   localparam int CUR_W       = 16;
   localparam int DATA_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int TOTAL_W     = CUR_W + $clog2(MOTOR_COUNT);
   localparam int IDX_W       = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int DIV_STEPS   = DATA_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 3;
   localparam int STATUS_W    = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF_BUFFER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WARNING_BUFFER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARNING_POWER  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CEILING_POWER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_UNRESTR_LIMIT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEBUFF_LIMIT   = 3'd6;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_PASS   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SCALED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CUT    = 2'd2;

   localparam logic [DATA_W-1:0] BUF_TEN_J    = 16'd160;
   localparam logic [7:0]        ID_NONE      = 8'd0;
   localparam logic [7:0]        ID_ENG_RED   = 8'd2;
   localparam logic [7:0]        ID_ENG_BLUE  = 8'd102;
   localparam logic [DATA_W-1:0] LEVEL_MAX    = 16'd101;

   typedef logic [MOTOR_COUNT-1:0][CUR_W-1:0] cur_vec_type;

   typedef struct packed {
      cur_vec_type          cur;
      logic [TOTAL_W-1:0]   total;
      logic                 cut;
      logic                 need_div;
      logic [DATA_W-1:0]    direct_limit;
      logic [PROD_W-1:0]    num;
      logic [DATA_W-1:0]    den;
   } job_type;

   function automatic logic [DATA_W-1:0] level_floor(input logic [DATA_W-1:0] level);
      logic [DATA_W-1:0] lv;
      logic [DATA_W-1:0] res;
      lv = (level > LEVEL_MAX) ? 16'd50 : level;
      unique case (lv)
         16'd55:  res = 16'd2292;
         16'd60:  res = 16'd2500;
         16'd65:  res = 16'd2708;
         16'd70:  res = 16'd2916;
         16'd90:  res = 16'd3750;
         default: res = 16'd2080;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/mcpl_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcpl_front import mcpl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data,
   input  wire logic                 referee_offline,
   input  wire logic [7:0]           unit_id,
   input  wire logic [DATA_W-1:0]    power_level,
   input  wire logic [DATA_W-1:0]    meas_power,
   input  wire logic [DATA_W-1:0]    buffer_energy,
   input  wire cur_vec_type          motor_current,
   output job_type                   job
);

   logic [DATA_W-1:0] cutoff_ff, warn_buf_ff, warn_pow_ff, ceil_pow_ff;
   logic [DATA_W-1:0] full_ff, unrestr_ff, debuff_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff   <= 16'd48;
         warn_buf_ff <= 16'd640;
         warn_pow_ff <= 16'd6400;
         ceil_pow_ff <= 16'd8000;
         full_ff     <= 16'd64000;
         unrestr_ff  <= 16'd64000;
         debuff_ff   <= 16'd16000;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_CUTOFF_BUFFER:  cutoff_ff   <= csr_data;
            REG_WARNING_BUFFER: warn_buf_ff <= csr_data;
            REG_WARNING_POWER:  warn_pow_ff <= csr_data;
            REG_CEILING_POWER:  ceil_pow_ff <= csr_data;
            REG_FULL_LIMIT:     full_ff     <= csr_data;
            REG_UNRESTR_LIMIT:  unrestr_ff  <= csr_data;
            REG_DEBUFF_LIMIT:   debuff_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   logic [TOTAL_W-1:0] total;
   logic [DATA_W-1:0]  mul_a, mul_b;
   logic               exempt;

   always_comb begin
      total = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         total = total + TOTAL_W'(motor_current[i][CUR_W-1] ?
                                  CUR_W'(-motor_current[i]) : motor_current[i]);
      end
   end

   assign exempt = referee_offline || unit_id == ID_NONE || unit_id == ID_ENG_RED ||
                   unit_id == ID_ENG_BLUE;

   always_comb begin
      job.cur          = motor_current;
      job.total        = total;
      job.cut          = buffer_energy <= cutoff_ff;
      job.need_div     = 1'b0;
      job.direct_limit = full_ff;
      job.den          = warn_buf_ff;
      mul_a            = debuff_ff;
      mul_b            = buffer_energy;
      priority if (exempt) begin
         job.direct_limit = unrestr_ff;
      end else if (buffer_energy < warn_buf_ff) begin
         if (buffer_energy > BUF_TEN_J) begin
            job.need_div = 1'b1;
         end else begin
            job.direct_limit = level_floor(power_level);
         end
      end else if (meas_power > warn_pow_ff) begin
         if (meas_power < ceil_pow_ff) begin
            // taper between warning and ceiling power
            job.need_div = 1'b1;
            job.den      = ceil_pow_ff - warn_pow_ff;
            mul_a        = full_ff;
            mul_b        = ceil_pow_ff - meas_power;
         end else begin
            job.direct_limit = '0;
         end
      end else begin
         job.direct_limit = full_ff;
      end
      job.num = mul_a * mul_b;
   end

endmodule
`default_nettype wire

[hw/rtl/mcpl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcpl_queue import mcpl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      head,
   output logic         empty
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push, do_pop;

   assign full    = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
      end
   end

endmodule
`default_nettype wire

[hw/rtl/mcpl_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcpl_back import mcpl_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire job_type        head,
   input  wire logic           q_empty,
   output logic                q_pop,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output cur_vec_type         rsp_cur,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [DATA_W-1:0]   rsp_limit
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIVLIM = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_LOAD   = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   logic [2:0]          state_ff, state_in;
   job_type             job_ff, job_in;
   logic [DATA_W-1:0]   limit_ff, limit_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [TOTAL_W-1:0]  rem_ff, rem_in, div_ff, div_in;
   logic [DATA_W-1:0]   dlo_ff, dlo_in, quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   cur_vec_type         res_ff, res_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                out_valid_ff, out_valid_in;
   cur_vec_type         out_cur_ff, out_cur_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [DATA_W-1:0]   out_limit_ff, out_limit_in;

   // one quotient bit per cycle
   logic [TOTAL_W:0]    trial, diff;
   logic                ge;
   logic [TOTAL_W-1:0]  rem_nx;
   logic [DATA_W-1:0]   quo_nx;
   logic [CUR_W-1:0]    cur_sel, mag;
   logic [PROD_W-1:0]   prod;

   assign trial  = {rem_ff, dlo_ff[DATA_W-1]};
   assign ge     = trial >= {1'b0, div_ff};
   assign diff   = trial - {1'b0, div_ff};
   assign rem_nx = ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
   assign quo_nx = {quo_ff[DATA_W-2:0], ge};
   assign cur_sel = job_ff.cur[idx_ff];
   assign mag     = cur_sel[CUR_W-1] ? CUR_W'(-cur_sel) : cur_sel;
   assign prod    = mag * limit_ff;

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      limit_in      = limit_ff;
      idx_in        = idx_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      dlo_in        = dlo_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      out_cur_in    = out_cur_ff;
      out_status_in = out_status_ff;
      out_limit_in  = out_limit_ff;
      q_pop         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               job_in = head;
               cnt_in = '0;
               quo_in = '0;
               priority if (head.cut) begin
                  res_in    = '0;
                  status_in = STATUS_CUT;
                  limit_in  = '0;
                  state_in  = ST_DONE;
               end else if (head.need_div) begin
                  rem_in   = TOTAL_W'(head.num[PROD_W-1:DATA_W]);
                  dlo_in   = head.num[DATA_W-1:0];
                  div_in   = TOTAL_W'(head.den);
                  state_in = ST_DIVLIM;
               end else begin
                  limit_in = head.direct_limit;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DIVLIM: begin
            rem_in = rem_nx;
            dlo_in = {dlo_ff[DATA_W-2:0], 1'b0};
            quo_in = quo_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               limit_in = quo_nx;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (job_ff.total > TOTAL_W'(limit_ff)) begin
               idx_in    = '0;
               status_in = STATUS_SCALED;
               state_in  = ST_LOAD;
            end else begin
               res_in    = job_ff.cur;
               status_in = STATUS_PASS;
               state_in  = ST_DONE;
            end
         end
         ST_LOAD: begin
            rem_in   = TOTAL_W'(prod[PROD_W-1:DATA_W]);
            dlo_in   = prod[DATA_W-1:0];
            div_in   = job_ff.total;
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            rem_in = rem_nx;
            dlo_in = {dlo_ff[DATA_W-2:0], 1'b0};
            quo_in = quo_nx;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               res_in[idx_ff] = cur_sel[CUR_W-1] ? CUR_W'(-quo_nx) : quo_nx;
               if (idx_ff == IDX_W'(MOTOR_COUNT - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in  = 1'b1;
               out_cur_in    = res_ff;
               out_status_in = status_ff;
               out_limit_in  = limit_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      limit_ff      <= limit_in;
      idx_ff        <= idx_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      dlo_ff        <= dlo_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      out_cur_ff    <= out_cur_in;
      out_status_ff <= out_status_in;
      out_limit_ff  <= out_limit_in;
   end

   assign rsp_empty  = !out_valid_ff;
   assign rsp_cur    = out_cur_ff;
   assign rsp_status = out_status_ff;
   assign rsp_limit  = out_limit_ff;

   a_cut_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff == STATUS_CUT |-> out_limit_ff == '0 && out_cur_ff == '0)
      else $error("cut word with non-zero payload");

   a_div_not_cut: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVLIM || state_ff == ST_SCALE |-> !job_ff.cut)
      else $error("divider running on a cut word");

   a_load_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result register loaded outside done state");

endmodule
`default_nettype wire

[hw/rtl/motor_current_power_limiter_unit.sv]
// motor current power limiter
// input queue: drive req_* fields with push; a word is taken on a clock edge
// where push is high and full is low. each word is one control tick.
// result queue: while empty is low the oldest result is on rsp_*; it is taken
// on an edge where pop is high. one result per tick, in order.
// csr port: csr_valid/csr_ready with csr_index and csr_data; csr_ready is always
// high, indexes beyond the register list are ignored. write only while idle.
// path: a cut-off tick goes from the queue head through the done state to the
// output register, a passed tick also passes the check state, a tick that needs
// the limit division runs the divider on the way, and a scaled tick runs it again
// per motor on top, since one shared radix-2 divider produces one quotient bit
// per cycle. a two-entry queue lets the front keep taking ticks while the
// divider works.
// reset: synchronous, active high; both queues empty, registers to defaults.
// receiver stall: a finished result waits in the output register, the back end
// holds its next result, and full rises once the two-entry queue fills.
`timescale 1ns / 1ps
`default_nettype none
module motor_current_power_limiter_unit import mcpl_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DATA_W-1:0]    csr_data,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic                 req_referee_offline,
   input  wire logic [7:0]           req_unit_id,
   input  wire logic [DATA_W-1:0]    req_power_level,
   input  wire logic [DATA_W-1:0]    req_meas_power,
   input  wire logic [DATA_W-1:0]    req_buffer_energy,
   input  wire logic signed [CUR_W-1:0] req_motor_current_0,
   input  wire logic signed [CUR_W-1:0] req_motor_current_1,
   input  wire logic signed [CUR_W-1:0] req_motor_current_2,
   input  wire logic signed [CUR_W-1:0] req_motor_current_3,
   output logic                      empty,
   input  wire logic                 pop,
   output logic signed [CUR_W-1:0]   rsp_limited_current_0,
   output logic signed [CUR_W-1:0]   rsp_limited_current_1,
   output logic signed [CUR_W-1:0]   rsp_limited_current_2,
   output logic signed [CUR_W-1:0]   rsp_limited_current_3,
   output logic [STATUS_W-1:0]       rsp_limit_status,
   output logic [DATA_W-1:0]         rsp_applied_limit
);

   cur_vec_type cur_in, cur_out;
   job_type     new_job, head_job;
   logic        q_empty, q_pop;

   assign cur_in[0] = req_motor_current_0;
   assign cur_in[1] = req_motor_current_1;
   assign cur_in[2] = req_motor_current_2;
   assign cur_in[3] = req_motor_current_3;

   mcpl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .referee_offline (req_referee_offline),
      .unit_id         (req_unit_id),
      .power_level     (req_power_level),
      .meas_power      (req_meas_power),
      .buffer_energy   (req_buffer_energy),
      .motor_current   (cur_in),
      .job             (new_job)
   );

   mcpl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (new_job),
      .full     (full),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty)
   );

   mcpl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_job),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_empty  (empty),
      .rsp_pop    (pop),
      .rsp_cur    (cur_out),
      .rsp_status (rsp_limit_status),
      .rsp_limit  (rsp_applied_limit)
   );

   assign rsp_limited_current_0 = cur_out[0];
   assign rsp_limited_current_1 = cur_out[1];
   assign rsp_limited_current_2 = cur_out[2];
   assign rsp_limited_current_3 = cur_out[3];

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
   import mcpl_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int N_MOTOR = MOTOR_COUNT;

   typedef struct {
      logic                    offline;
      logic [7:0]              unit_id;
      logic [DATA_W-1:0]       level;
      logic [DATA_W-1:0]       power;
      logic [DATA_W-1:0]       energy;
      logic signed [CUR_W-1:0] cur [N_MOTOR];
   } tick_type;

   typedef struct {
      logic signed [CUR_W-1:0] cur [N_MOTOR];
      logic [STATUS_W-1:0]     status;
      logic [DATA_W-1:0]       limit;
   } limited_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;
   logic csr_ready;
   logic push = 1'b0;
   logic full;
   logic req_referee_offline = 1'b0;
   logic [7:0] req_unit_id = '0;
   logic [DATA_W-1:0] req_power_level = '0;
   logic [DATA_W-1:0] req_meas_power = '0;
   logic [DATA_W-1:0] req_buffer_energy = '0;
   logic signed [CUR_W-1:0] req_mc0 = '0, req_mc1 = '0, req_mc2 = '0, req_mc3 = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [CUR_W-1:0] rsp_lc0, rsp_lc1, rsp_lc2, rsp_lc3;
   logic [STATUS_W-1:0] rsp_limit_status;
   logic [DATA_W-1:0] rsp_applied_limit;

   // shadow copies of the limiter registers
   logic [DATA_W-1:0] cfg_regs [7];

   limited_type expected_q [$];
   int errors = 0;
   int ticks_sent = 0;
   int results_seen = 0;
   int scaled_seen = 0;
   int cut_seen = 0;
   int cycles = 0;
   int hold_request = 0;
   int stall_left = 0;

   motor_current_power_limiter_unit u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .push(push), .full(full),
      .req_referee_offline(req_referee_offline), .req_unit_id(req_unit_id),
      .req_power_level(req_power_level), .req_meas_power(req_meas_power),
      .req_buffer_energy(req_buffer_energy),
      .req_motor_current_0(req_mc0), .req_motor_current_1(req_mc1),
      .req_motor_current_2(req_mc2), .req_motor_current_3(req_mc3),
      .empty(empty), .pop(pop),
      .rsp_limited_current_0(rsp_lc0), .rsp_limited_current_1(rsp_lc1),
      .rsp_limited_current_2(rsp_lc2), .rsp_limited_current_3(rsp_lc3),
      .rsp_limit_status(rsp_limit_status), .rsp_applied_limit(rsp_applied_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("run exceeded cycle limit");
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] floor_for_level(logic [DATA_W-1:0] level);
      logic [DATA_W-1:0] lv;
      lv = (level > 16'd101) ? 16'd50 : level;
      unique case (lv)
         16'd55:  return 16'd2292;
         16'd60:  return 16'd2500;
         16'd65:  return 16'd2708;
         16'd70:  return 16'd2916;
         16'd90:  return 16'd3750;
         default: return 16'd2080;
      endcase
   endfunction

   function automatic limited_type limit_currents(tick_type t);
      limited_type res;
      longint total, mag, lim, q;
      longint cutoff, wbuf, wpow, ceil_p, full_l, unres, debuff;
      cutoff = cfg_regs[REG_CUTOFF_BUFFER];
      wbuf   = cfg_regs[REG_WARNING_BUFFER];
      wpow   = cfg_regs[REG_WARNING_POWER];
      ceil_p = cfg_regs[REG_CEILING_POWER];
      full_l = cfg_regs[REG_FULL_LIMIT];
      unres  = cfg_regs[REG_UNRESTR_LIMIT];
      debuff = cfg_regs[REG_DEBUFF_LIMIT];
      total = 0;
      for (int i = 0; i < N_MOTOR; i++)
         total += (t.cur[i] < 0) ? -longint'(t.cur[i]) : longint'(t.cur[i]);
      if (longint'(t.energy) <= cutoff) begin
         foreach (res.cur[i]) res.cur[i] = '0;
         res.status = STATUS_CUT;
         res.limit = '0;
         return res;
      end
      if (t.offline || t.unit_id == ID_NONE || t.unit_id == ID_ENG_RED ||
          t.unit_id == ID_ENG_BLUE) begin
         lim = unres;
      end else if (longint'(t.energy) < wbuf) begin
         if (t.energy > BUF_TEN_J) lim = debuff * longint'(t.energy) / wbuf;
         else lim = floor_for_level(t.level);
      end else if (longint'(t.power) > wpow) begin
         if (longint'(t.power) < ceil_p)
            lim = full_l * (ceil_p - longint'(t.power)) / (ceil_p - wpow);
         else lim = 0;
      end else begin
         lim = full_l;
      end
      if (lim > 65535) lim = 65535;
      if (total > lim) begin
         for (int i = 0; i < N_MOTOR; i++) begin
            mag = (t.cur[i] < 0) ? -longint'(t.cur[i]) : longint'(t.cur[i]);
            q = mag * lim / total;
            res.cur[i] = (t.cur[i] < 0) ? CUR_W'(-q) : CUR_W'(q);
         end
         res.status = STATUS_SCALED;
      end else begin
         foreach (res.cur[i]) res.cur[i] = t.cur[i];
         res.status = STATUS_PASS;
      end
      res.limit = DATA_W'(lim);
      return res;
   endfunction

   // result side: check accepted words, choose pop for next edge
   always @(posedge clock) begin
      limited_type e;
      int r;
      if (!reset) begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("result with nothing expected");
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (e.status == STATUS_SCALED) scaled_seen++;
               if (e.status == STATUS_CUT) cut_seen++;
               if (rsp_lc0 !== e.cur[0]) begin
                  $error("limited_current_0 exp %0d got %0d", e.cur[0], rsp_lc0); errors++;
               end
               if (rsp_lc1 !== e.cur[1]) begin
                  $error("limited_current_1 exp %0d got %0d", e.cur[1], rsp_lc1); errors++;
               end
               if (rsp_lc2 !== e.cur[2]) begin
                  $error("limited_current_2 exp %0d got %0d", e.cur[2], rsp_lc2); errors++;
               end
               if (rsp_lc3 !== e.cur[3]) begin
                  $error("limited_current_3 exp %0d got %0d", e.cur[3], rsp_lc3); errors++;
               end
               if (rsp_limit_status !== e.status) begin
                  $error("limit_status exp %0d got %0d", e.status, rsp_limit_status);
                  errors++;
               end
               if (rsp_applied_limit !== e.limit) begin
                  $error("applied_limit exp %0d got %0d", e.limit, rsp_applied_limit);
                  errors++;
               end
            end
         end
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) stall_left = 0;
            else if (r < 95) stall_left = $urandom_range(1, 4);
            else stall_left = $urandom_range(10, 60);
            pop <= (stall_left == 0);
         end
      end
   end

   task automatic send_tick(tick_type t);
      req_referee_offline <= t.offline;
      req_unit_id <= t.unit_id;
      req_power_level <= t.level;
      req_meas_power <= t.power;
      req_buffer_energy <= t.energy;
      req_mc0 <= t.cur[0];
      req_mc1 <= t.cur[1];
      req_mc2 <= t.cur[2];
      req_mc3 <= t.cur[3];
      push <= 1'b1;
      do @(posedge clock); while (full);
      expected_q.push_back(limit_currents(t));
      ticks_sent++;
   endtask

   task automatic sender_gap(bit no_gaps);
      int r, n;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) n = 0;
      else if (r < 93) n = $urandom_range(1, 4);
      else n = $urandom_range(10, 50);
      if (n > 0) begin
         push <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      cfg_regs[idx] = val;
   endtask

   task automatic load_config(int cb, int wb, int wp, int cp, int fl, int ul, int dl);
      write_reg(REG_CUTOFF_BUFFER, DATA_W'(cb));
      write_reg(REG_WARNING_BUFFER, DATA_W'(wb));
      write_reg(REG_WARNING_POWER, DATA_W'(wp));
      write_reg(REG_CEILING_POWER, DATA_W'(cp));
      write_reg(REG_FULL_LIMIT, DATA_W'(fl));
      write_reg(REG_UNRESTR_LIMIT, DATA_W'(ul));
      write_reg(REG_DEBUFF_LIMIT, DATA_W'(dl));
      csr_valid <= 1'b0;
   endtask

   function automatic tick_type make_tick(int offl, int id, int lvl, int pw, int en,
                                          int c0, int c1, int c2, int c3);
      tick_type t;
      t.offline = offl[0];
      t.unit_id = id[7:0];
      t.level = lvl[15:0];
      t.power = pw[15:0];
      t.energy = en[15:0];
      t.cur[0] = c0[15:0]; t.cur[1] = c1[15:0]; t.cur[2] = c2[15:0]; t.cur[3] = c3[15:0];
      return t;
   endfunction

   function automatic logic [15:0] near(int centre);
      int v;
      v = centre + $urandom_range(0, 8) - 4;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // mostly meaningful ticks: ids, levels and energies near the decision points
   function automatic tick_type random_tick();
      tick_type t;
      int r;
      logic [15:0] levels [8] = '{16'd50, 16'd55, 16'd60, 16'd65, 16'd70, 16'd90,
                                  16'd101, 16'd102};
      t.offline = ($urandom_range(0, 9) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) t.unit_id = ID_NONE;
      else if (r == 1) t.unit_id = ID_ENG_RED;
      else if (r == 2) t.unit_id = ID_ENG_BLUE;
      else t.unit_id = 8'($urandom_range(0, 255));
      t.level = ($urandom_range(0, 3) == 0) ? 16'($urandom) : levels[$urandom_range(0, 7)];
      r = $urandom_range(0, 5);
      case (r)
         0: t.energy = near(cfg_regs[REG_CUTOFF_BUFFER]);
         1: t.energy = near(cfg_regs[REG_WARNING_BUFFER]);
         2: t.energy = near(BUF_TEN_J);
         3: t.energy = 16'($urandom_range(0, 1000));
         default: t.energy = 16'($urandom);
      endcase
      r = $urandom_range(0, 4);
      case (r)
         0: t.power = near(cfg_regs[REG_WARNING_POWER]);
         1: t.power = near(cfg_regs[REG_CEILING_POWER]);
         2: t.power = 16'($urandom_range(0, 10000));
         default: t.power = 16'($urandom);
      endcase
      r = $urandom_range(0, 9);
      for (int i = 0; i < N_MOTOR; i++) begin
         if (r == 0) t.cur[i] = '0;
         else if (r < 4) t.cur[i] = 16'($urandom_range(0, 4000) - 2000);
         else if (r == 4) t.cur[i] = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
         else t.cur[i] = 16'($urandom);
      end
      return t;
   endfunction

   task automatic run_random(int n, bit no_gaps);
      repeat (n) begin
         send_tick(random_tick());
         sender_gap(no_gaps);
      end
   endtask

   task automatic test_directed();
      tick_type d [$];
      d.push_back(make_tick(0, 5, 50, 1000, 48, 1000, -1000, 500, -500));
      d.push_back(make_tick(1, 5, 50, 1000, 0, 32767, 32767, 32767, 32767));
      d.push_back(make_tick(0, 0, 50, 9000, 49, 32767, 32767, -32768, -32768));
      d.push_back(make_tick(0, 2, 50, 9000, 100, 20000, 20000, 20000, 20000));
      d.push_back(make_tick(0, 102, 50, 9000, 100, -20000, 20000, -20000, 20000));
      d.push_back(make_tick(1, 7, 50, 9000, 100, 30000, 30000, 1, -1));
      d.push_back(make_tick(0, 7, 50, 1000, 400, 9000, -9000, 3000, 1));
      d.push_back(make_tick(0, 7, 50, 1000, 639, 9000, -9000, 3000, 1));
      d.push_back(make_tick(0, 7, 50, 1000, 161, 100, 100, 100, 100));
      d.push_back(make_tick(0, 7, 50, 1000, 160, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 55, 1000, 160, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 60, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 65, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 70, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 90, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 101, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 102, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 255, 65535, 1000, 100, 5000, 5000, -5000, 5000));
      d.push_back(make_tick(0, 7, 50, 7000, 640, 32767, -32768, 32767, -32768));
      d.push_back(make_tick(0, 7, 50, 6401, 65535, 32767, 32767, 32767, 32767));
      d.push_back(make_tick(0, 7, 50, 8000, 65535, 10, -10, 10, -10));
      d.push_back(make_tick(0, 7, 50, 65535, 65535, 10, -10, 10, -10));
      d.push_back(make_tick(0, 7, 50, 6400, 65535, 32767, 32767, 32767, 32767));
      d.push_back(make_tick(0, 7, 50, 0, 65535, 0, 0, 0, 0));
      d.push_back(make_tick(0, 7, 50, 65535, 65535, 0, 0, 0, 0));
      foreach (d[i]) begin
         send_tick(d[i]);
         sender_gap(0);
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_request = 400;
      @(posedge clock);
      run_random(12, 1);
      wait_drained();
   endtask

   task automatic test_config_extremes();
      // zero limits, warning buffer of one
      load_config(0, 1, 0, 0, 0, 0, 0);
      run_random(30, 0);
      wait_drained();
      // everything cut off
      load_config(65535, 65535, 65535, 65535, 65535, 65535, 65535);
      run_random(30, 0);
      wait_drained();
      // inverted taper bounds
      load_config(10, 65535, 9000, 8000, 65535, 65535, 65535);
      run_random(30, 0);
      wait_drained();
      // no low-buffer branch, wide taper
      load_config(0, 0, 100, 65535, 65535, 1, 65535);
      run_random(30, 0);
      wait_drained();
   endtask

   task automatic test_random_configs();
      for (int p = 0; p < 10; p++) begin
         if (p == 0) load_config(48, 640, 6400, 8000, 64000, 64000, 16000);
         else load_config($urandom_range(0, 400), $urandom_range(0, 3000),
                          $urandom_range(0, 12000), $urandom_range(0, 12000),
                          16'($urandom), 16'($urandom), 16'($urandom));
         run_random(100, p == 3);
         wait_drained();
      end
   endtask

   initial begin
      cfg_regs = '{16'd48, 16'd640, 16'd6400, 16'd8000, 16'd64000, 16'd64000, 16'd16000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_config_extremes();
      test_random_configs();
      wait_drained();
      repeat (100) @(posedge clock);
      $display("%0d ticks sent, %0d results checked (%0d scaled, %0d cut off)",
               ticks_sent, results_seen, scaled_seen, cut_seen);
      $display("covered level floors, exempt ids, taper, register extremes, backpressure");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (expected_q.size() != 0) $error("%0d results never arrived", expected_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
